FILE: src/pee_pkg.sv
// Shared types and character codes for the postfix expression evaluator.
package pee_pkg;

   localparam int VALUE_WIDTH = 32;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LO_A    = 8'h61;
   localparam logic [7:0] CHAR_LO_Z    = 8'h7A;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_REM
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_sts_type;

   function automatic logic is_alnum(logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
             (c >= CHAR_LO_A && c <= CHAR_LO_Z);
   endfunction

endpackage

FILE: src/pee_chan_if.sv
// Valid/ready channel interfaces for character words and result words.
interface pee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface pee_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pee_pkg::VALUE_WIDTH-1:0]   value;
   pee_pkg::status_type                      status;

   modport source (output valid, output value, output status, input ready);
   modport sink (input valid, input value, input status, output ready);
endinterface

FILE: src/pee_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pee_alu.sv
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
module pee_alu #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pee_pkg::alu_ctl_type  ctl,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-1:0] b,
   output pee_pkg::alu_sts_type  sts,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int DW        = DATA_WIDTH;
   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);

   typedef enum logic [2:0] {
      A_IDLE,
      A_ADDSUB,
      A_MUL,
      A_DIV,
      A_FIX,
      A_DONE
   } state_type;

   state_type             state_ff, state_in;
   pee_pkg::op_type       op_ff, op_in;
   logic [DW-1:0]         acc_ff, acc_in;
   logic [DW-1:0]         x_ff, x_in;
   logic [DW-1:0]         y_ff, y_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  dz_ff, dz_in;

   logic [DW:0]           add_x, add_y, sum;
   logic                  add_cin;
   logic [DW:0]           rem_shift;
   logic [DW-1:0]         fix_val;
   logic [DW-1:0]         a_mag, b_mag;
   logic                  is_sub;

   assign rem_shift = {acc_ff, x_ff[DW-1]};
   assign fix_val   = (op_ff == pee_pkg::OP_DIV) ? x_ff : acc_ff;
   assign a_mag     = a[DW-1] ? (~a + DW'(1)) : a;
   assign b_mag     = b[DW-1] ? (~b + DW'(1)) : b;
   assign is_sub    = (op_ff == pee_pkg::OP_SUB);

   // the one adder every operation goes through
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_cin = 1'b0;
      case (state_ff)
         A_ADDSUB: begin
            add_x   = {1'b0, x_ff};
            add_y   = is_sub ? ~{1'b0, y_ff} : {1'b0, y_ff};
            add_cin = is_sub;
         end
         A_MUL: begin
            add_x = {1'b0, acc_ff};
            add_y = {1'b0, (y_ff[0] ? x_ff : {DW{1'b0}})};
         end
         A_DIV: begin
            add_x   = rem_shift;
            add_y   = ~{1'b0, y_ff};
            add_cin = 1'b1;
         end
         A_FIX: begin
            add_y   = ~{1'b0, fix_val};
            add_cin = 1'b1;
         end
         default: begin
            add_x = '0;
         end
      endcase
      sum = add_x + add_y + {{DW{1'b0}}, add_cin};
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      dz_in    = dz_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               op_in  = ctl.op;
               dz_in  = 1'b0;
               acc_in = '0;
               cnt_in = CNT_WIDTH'(DW - 1);
               case (ctl.op)
                  pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
                     x_in     = a;
                     y_in     = b;
                     state_in = A_ADDSUB;
                  end
                  pee_pkg::OP_MUL: begin
                     x_in     = a;
                     y_in     = b;
                     state_in = A_MUL;
                  end
                  pee_pkg::OP_DIV, pee_pkg::OP_REM: begin
                     if (b == '0) begin
                        dz_in    = 1'b1;
                        state_in = A_DONE;
                     end else begin
                        x_in     = a_mag;
                        y_in     = b_mag;
                        neg_in   = (ctl.op == pee_pkg::OP_DIV) ? (a[DW-1] ^ b[DW-1]) : a[DW-1];
                        state_in = A_DIV;
                     end
                  end
                  default: begin
                     state_in = A_DONE;
                  end
               endcase
            end
         end
         A_ADDSUB: begin
            acc_in   = sum[DW-1:0];
            state_in = A_DONE;
         end
         A_MUL: begin
            acc_in = sum[DW-1:0];
            x_in   = {x_ff[DW-2:0], 1'b0};
            y_in   = {1'b0, y_ff[DW-1:1]};
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               state_in = A_DONE;
            end
         end
         A_DIV: begin
            acc_in = sum[DW] ? rem_shift[DW-1:0] : sum[DW-1:0];
            x_in   = {x_ff[DW-2:0], ~sum[DW]};
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            acc_in   = neg_ff ? sum[DW-1:0] : fix_val;
            state_in = A_DONE;
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
   end

   assign sts.done     = (state_ff == A_DONE);
   assign sts.div_zero = dz_ff;
   assign result       = acc_ff;

endmodule

FILE: src/postfix_expression_evaluator.sv
// Postfix expression evaluator: top level with stack sequencer and result register.
//
// Takes one character word per handshake and evaluates the postfix expression on a
// stack of STACK_DEPTH entries of DATA_WIDTH bits held in RAM. A digit or letter
// is pushed onto the stack. An operator pops two entries from the RAM (registered
// read, one entry a cycle) and runs on one shared adder: + and - as an add or
// subtract, * as one shift-add a cycle, / and % as one restoring step a cycle. A
// word with last set reads the top of the stack into the result register; the
// result word may wait there while the next expression is taken in. The input is not
// ready while an operator or the end of an expression is in progress.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input logic       clock,
   input logic       reset,
   pee_req_if.sink   req_chan,
   pee_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int VW = pee_pkg::VALUE_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_B,
      S_POP_A,
      S_LOAD,
      S_EXEC,
      S_FIN_RD,
      S_FIN_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   pee_pkg::status_type  err_ff, err_in;
   logic                 stop_ff, stop_in;
   logic                 last_ff, last_in;
   pee_pkg::op_type      op_ff, op_in;
   logic                 hit_ff, hit_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_value_ff, rsp_value_in;
   pee_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  push_en;
   logic [DATA_WIDTH-1:0] push_data;
   logic                  ram_wr_en;
   logic [CW-1:0]         count_dec;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [DATA_WIDTH-1:0] alu_a;
   logic [DATA_WIDTH-1:0] alu_result;
   pee_pkg::alu_ctl_type  alu_ctl;
   pee_pkg::alu_sts_type  alu_sts;

   assign count_dec = count_ff - CW'(1);
   assign ram_wr_en = push_en && (count_ff < CW'(STACK_DEPTH));
   assign alu_a     = hit_ff ? rd_data : '0;

   pee_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (push_data),
      .rd_addr (count_dec[AW-1:0]),
      .rd_data (rd_data)
   );

   pee_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (alu_a),
      .b      (b_ff),
      .sts    (alu_sts),
      .result (alu_result)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      stop_in       = stop_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      hit_in        = hit_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      push_en       = 1'b0;
      push_data     = DATA_WIDTH'(req_chan.ch) - DATA_WIDTH'(pee_pkg::CHAR_ZERO);
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               last_in  = req_chan.last;
               state_in = req_chan.last ? S_FIN_RD : S_IDLE;
               if (!stop_ff) begin
                  case (req_chan.ch)
                     pee_pkg::CHAR_CLOSE: begin
                        stop_in = 1'b1;
                     end
                     pee_pkg::CHAR_PLUS: begin
                        op_in    = pee_pkg::OP_ADD;
                        state_in = S_POP_B;
                     end
                     pee_pkg::CHAR_MINUS: begin
                        op_in    = pee_pkg::OP_SUB;
                        state_in = S_POP_B;
                     end
                     pee_pkg::CHAR_STAR: begin
                        op_in    = pee_pkg::OP_MUL;
                        state_in = S_POP_B;
                     end
                     pee_pkg::CHAR_SLASH: begin
                        op_in    = pee_pkg::OP_DIV;
                        state_in = S_POP_B;
                     end
                     pee_pkg::CHAR_PERCENT: begin
                        op_in    = pee_pkg::OP_REM;
                        state_in = S_POP_B;
                     end
                     default: begin
                        push_en = pee_pkg::is_alnum(req_chan.ch);
                     end
                  endcase
               end
            end
         end
         S_POP_B: begin
            hit_in = (count_ff != '0);
            if (count_ff != '0) begin
               count_in = count_dec;
            end
            state_in = S_POP_A;
         end
         S_POP_A: begin
            b_in   = hit_ff ? rd_data : '0;
            hit_in = (count_ff != '0);
            if (count_ff != '0) begin
               count_in = count_dec;
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            alu_ctl.start = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            push_data = alu_result;
            if (alu_sts.done) begin
               if (alu_sts.div_zero && err_ff == pee_pkg::STATUS_OK) begin
                  err_in = pee_pkg::STATUS_DIV_ZERO;
               end
               push_en  = 1'b1;
               state_in = last_ff ? S_FIN_RD : S_IDLE;
            end
         end
         S_FIN_RD: begin
            state_in = S_FIN_OUT;
         end
         S_FIN_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (count_ff != '0 && err_ff == pee_pkg::STATUS_OK) ?
                               VW'(rd_data) : '0;
               rsp_status_in = err_ff;
               count_in      = '0;
               err_in        = pee_pkg::STATUS_OK;
               stop_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // push after any error noted above, so the first error wins
      if (push_en) begin
         if (count_ff < CW'(STACK_DEPTH)) begin
            count_in = count_ff + CW'(1);
         end else if (err_in == pee_pkg::STATUS_OK) begin
            err_in = pee_pkg::STATUS_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= pee_pkg::STATUS_OK;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      op_ff         <= op_in;
      hit_ff        <= hit_in;
      b_ff          <= b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule
